// ===== design/firfc_pkg.sv =====
// firfc_pkg: sizes, codes, state encoding and tap-count helper for the full-convolution fir core
// used by fir_full_convolution_core, firfc_checker and the testbench; depends on nothing else
package firfc_pkg;

   // filter sizes
   localparam int MAX_TAPS       = 32;
   localparam int SAMPLE_BITS    = 16;
   localparam int COEF_BITS      = 18;
   localparam int FRAC_BITS      = COEF_BITS - 1;
   localparam int IDX_BITS       = $clog2(MAX_TAPS);
   localparam int CNT_BITS       = $clog2(MAX_TAPS + 1);
   localparam int TAP_CFG_BITS   = 6;
   localparam int TAP_INDEX_BITS = 5;
   localparam int PROD_BITS      = SAMPLE_BITS + COEF_BITS;
   localparam int ACC_BITS       = PROD_BITS + IDX_BITS + 1;

   // tap count after reset
   localparam logic [TAP_CFG_BITS-1:0] TAP_COUNT_RESET = TAP_CFG_BITS'(20);

   // command codes of an input word
   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   // sequencer states
   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_MAC   = 4'b0010,
      S_DRAIN = 4'b0100,
      S_FIN   = 4'b1000
   } state_type;

   // clamp the programmed tap count into 1..MAX_TAPS
   function automatic logic [CNT_BITS-1:0] active_taps(input logic [TAP_CFG_BITS-1:0] cfg);
      logic [CNT_BITS-1:0] n;
      if (cfg == '0) begin
         n = CNT_BITS'(1);
      end else if (int'(cfg) > MAX_TAPS) begin
         n = CNT_BITS'(MAX_TAPS);
      end else begin
         n = CNT_BITS'(cfg);
      end
      return n;
   endfunction

endpackage

// ===== design/firfc_ram.sv =====
// firfc_ram: generic single-write, single-read synchronous ram with registered read data
// standalone, no package dependency
module firfc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/fir_full_convolution_core.sv =====
// fir_full_convolution_core: direct-form fir producing the full convolution of a sample block
// depends on firfc_pkg and on firfc_ram for the coefficient and history memories

// A load word (cmd 0) writes one Q1.17 coefficient. A sample word (cmd 1) is
// written into the history ram and then one multiply-accumulate per active tap runs through
// a single multiplier fed by the coefficient and history rams, one tap per cycle. Each output
// passes through the tap reads, the registered read and multiply stages, a check that the
// pipeline has drained, and rounding and saturation. A sample marked last is followed by
// tap_count - 1 tail outputs; the history then clears at once through per-entry valid bits.
// The core takes one word at a time; a finished output waits in the output register while
// the next word is accepted, and a new output that finds that register still full waits
// until it is taken. tap_count is written on the csr port, which is always ready, and is
// clamped into 1..32.
module fir_full_convolution_core (
   input  logic                                    clock,
   input  logic                                    reset,
   // input words
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic                                    req_cmd,
   input  logic [firfc_pkg::TAP_INDEX_BITS-1:0]    req_tap_index,
   input  logic signed [firfc_pkg::COEF_BITS-1:0]  req_tap_value,
   input  logic signed [firfc_pkg::SAMPLE_BITS-1:0] req_sample,
   input  logic                                    req_last,
   // output words
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [firfc_pkg::SAMPLE_BITS-1:0] rsp_filtered,
   output logic                                    rsp_clipped,
   output logic                                    rsp_block_end,
   // tap count register
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [firfc_pkg::TAP_CFG_BITS-1:0]      csr_tap_count
);

   localparam int IB = firfc_pkg::IDX_BITS;
   localparam int CB = firfc_pkg::CNT_BITS;
   localparam int AB = firfc_pkg::ACC_BITS;
   localparam int PB = firfc_pkg::PROD_BITS;
   localparam int SB = firfc_pkg::SAMPLE_BITS;

   localparam logic signed [AB-1:0] SAT_HI = {{(AB-SB+1){1'b0}}, {(SB-1){1'b1}}};
   localparam logic signed [AB-1:0] SAT_LO = ~SAT_HI;
   localparam logic signed [AB-1:0] ROUND  = AB'(1) << (firfc_pkg::FRAC_BITS - 1);

   // control state
   firfc_pkg::state_type state_ff, state_in;
   logic [IB-1:0]                      wp_ff, wp_in;
   logic [firfc_pkg::MAX_TAPS-1:0]     hist_vld_ff, hist_vld_in;
   logic [CB-1:0]                      k_ff, k_in;
   logic [CB-1:0]                      ntaps_ff, ntaps_in;
   logic [CB-1:0]                      tail_ff, tail_in;
   logic                               last_ff, last_in;
   logic                               rd_vld_ff, rd_vld_in;
   logic                               prod_vld_ff, prod_vld_in;
   logic [firfc_pkg::TAP_CFG_BITS-1:0] tap_count_ff, tap_count_in;
   logic                               rsp_valid_ff, rsp_valid_in;

   // datapath
   logic                               hv_ff, hv_in;
   logic signed [PB-1:0]               prod_ff, prod_in;
   logic signed [AB-1:0]               acc_ff, acc_in;
   logic signed [SB-1:0]               rsp_filtered_ff, rsp_filtered_in;
   logic                               rsp_clipped_ff, rsp_clipped_in;
   logic                               rsp_block_end_ff, rsp_block_end_in;

   // memory ports
   logic                               coef_we;
   logic [IB-1:0]                      coef_waddr;
   logic                               hist_we;
   logic                               rd_en;
   logic [IB-1:0]                      hist_raddr;
   logic [IB:0]                        hist_diff;
   logic signed [firfc_pkg::COEF_BITS-1:0] coef_rd;
   logic signed [SB-1:0]               hist_rd;
   logic signed [SB-1:0]               hist_term;

   // helpers
   logic [IB-1:0]                      wp_plus;
   logic [CB-1:0]                      req_taps;
   logic signed [AB-1:0]               shifted;
   logic signed [SB-1:0]               sat_value;
   logic                               sat_clip;
   logic                               req_fire;

   firfc_ram #(.WIDTH(firfc_pkg::COEF_BITS), .DEPTH(firfc_pkg::MAX_TAPS)) u_coef_ram (
      .clock   (clock),
      .wr_en   (coef_we),
      .wr_addr (coef_waddr),
      .wr_data (req_tap_value),
      .rd_en   (rd_en),
      .rd_addr (k_ff[IB-1:0]),
      .rd_data (coef_rd)
   );

   firfc_ram #(.WIDTH(SB), .DEPTH(firfc_pkg::MAX_TAPS)) u_hist_ram (
      .clock   (clock),
      .wr_en   (hist_we),
      .wr_addr (wp_plus),
      .wr_data (req_sample),
      .rd_en   (rd_en),
      .rd_addr (hist_raddr),
      .rd_data (hist_rd)
   );

   assign req_ready = (state_ff == firfc_pkg::S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign coef_waddr = IB'(req_tap_index);

   // circular pointer helpers: next write slot and history slot of tap k
   always_comb begin
      wp_plus = (wp_ff == IB'(firfc_pkg::MAX_TAPS - 1)) ? '0 : wp_ff + 1'b1;
      hist_diff = {1'b0, wp_ff} - {1'b0, k_ff[IB-1:0]};
      if (hist_diff[IB]) begin
         hist_diff = hist_diff + (IB+1)'(firfc_pkg::MAX_TAPS);
      end
      hist_raddr = hist_diff[IB-1:0];
      req_taps   = firfc_pkg::active_taps(tap_count_ff);
   end

   // rounding is preloaded in the accumulator; shift and saturate here
   always_comb begin
      shifted = acc_ff >>> firfc_pkg::FRAC_BITS;
      if (shifted > SAT_HI) begin
         sat_value = SAT_HI[SB-1:0];
         sat_clip  = 1'b1;
      end else if (shifted < SAT_LO) begin
         sat_value = SAT_LO[SB-1:0];
         sat_clip  = 1'b1;
      end else begin
         sat_value = shifted[SB-1:0];
         sat_clip  = 1'b0;
      end
   end

   // history entries never written since the last clear read as zero
   assign hist_term = hv_ff ? hist_rd : '0;

   // sequencer and multiply-accumulate pipeline
   always_comb begin
      state_in         = state_ff;
      wp_in            = wp_ff;
      hist_vld_in      = hist_vld_ff;
      k_in             = k_ff;
      ntaps_in         = ntaps_ff;
      tail_in          = tail_ff;
      last_in          = last_ff;
      rd_vld_in        = 1'b0;
      tap_count_in     = csr_valid ? csr_tap_count : tap_count_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_filtered_in  = rsp_filtered_ff;
      rsp_clipped_in   = rsp_clipped_ff;
      rsp_block_end_in = rsp_block_end_ff;
      coef_we          = 1'b0;
      hist_we          = 1'b0;
      rd_en            = 1'b0;

      // read data to product to accumulator
      hv_in       = hist_vld_ff[hist_raddr];
      prod_vld_in = rd_vld_ff;
      prod_in     = coef_rd * hist_term;
      acc_in      = acc_ff;
      if (prod_vld_ff) begin
         acc_in = acc_ff + {{(AB-PB){prod_ff[PB-1]}}, prod_ff};
      end

      case (state_ff)
         firfc_pkg::S_IDLE: begin
            if (req_fire) begin
               if (req_cmd == firfc_pkg::CMD_LOAD) begin
                  coef_we = (int'(req_tap_index) < firfc_pkg::MAX_TAPS);
               end else begin
                  hist_we              = 1'b1;
                  hist_vld_in[wp_plus] = 1'b1;
                  wp_in                = wp_plus;
                  ntaps_in             = req_taps;
                  last_in              = req_last;
                  tail_in              = req_last ? req_taps - 1'b1 : '0;
                  k_in                 = '0;
                  acc_in               = ROUND;
                  state_in             = firfc_pkg::S_MAC;
               end
            end
         end
         firfc_pkg::S_MAC: begin
            // one tap per cycle; the history write finished before the first read
            rd_en     = 1'b1;
            rd_vld_in = 1'b1;
            k_in      = k_ff + 1'b1;
            if (k_ff == ntaps_ff - 1'b1) begin
               state_in = firfc_pkg::S_DRAIN;
            end
         end
         firfc_pkg::S_DRAIN: begin
            if (!rd_vld_ff && !prod_vld_ff) begin
               state_in = firfc_pkg::S_FIN;
            end
         end
         firfc_pkg::S_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in     = 1'b1;
               rsp_filtered_in  = sat_value;
               rsp_clipped_in   = sat_clip;
               rsp_block_end_in = last_ff && (tail_ff == '0);
               if (last_ff && (tail_ff != '0)) begin
                  // tail output: a zero enters the history
                  tail_in              = tail_ff - 1'b1;
                  wp_in                = wp_plus;
                  hist_vld_in[wp_plus] = 1'b0;
                  k_in                 = '0;
                  acc_in               = ROUND;
                  state_in             = firfc_pkg::S_MAC;
               end else begin
                  if (last_ff) begin
                     hist_vld_in = '0;
                     wp_in       = '0;
                  end
                  state_in = firfc_pkg::S_IDLE;
               end
            end
         end
         default: begin
            state_in = firfc_pkg::S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= firfc_pkg::S_IDLE;
         wp_ff        <= '0;
         hist_vld_ff  <= '0;
         k_ff         <= '0;
         ntaps_ff     <= '0;
         tail_ff      <= '0;
         last_ff      <= 1'b0;
         rd_vld_ff    <= 1'b0;
         prod_vld_ff  <= 1'b0;
         tap_count_ff <= firfc_pkg::TAP_COUNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         hist_vld_ff  <= hist_vld_in;
         k_ff         <= k_in;
         ntaps_ff     <= ntaps_in;
         tail_ff      <= tail_in;
         last_ff      <= last_in;
         rd_vld_ff    <= rd_vld_in;
         prod_vld_ff  <= prod_vld_in;
         tap_count_ff <= tap_count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      hv_ff            <= hv_in;
      prod_ff          <= prod_in;
      acc_ff           <= acc_in;
      rsp_filtered_ff  <= rsp_filtered_in;
      rsp_clipped_ff   <= rsp_clipped_in;
      rsp_block_end_ff <= rsp_block_end_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_filtered  = rsp_filtered_ff;
   assign rsp_clipped   = rsp_clipped_ff;
   assign rsp_block_end = rsp_block_end_ff;

   // tap counter stays inside the active taps while reading
   a_tap_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == firfc_pkg::S_MAC) |-> (k_ff < ntaps_ff))
      else $error("tap counter beyond active taps");

   // rounding only starts on a drained pipeline
   a_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == firfc_pkg::S_FIN) |-> (!rd_vld_ff && !prod_vld_ff))
      else $error("result taken before accumulation finished");

   // a read in flight was issued by the tap loop
   a_read_origin: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> $past(state_ff == firfc_pkg::S_MAC))
      else $error("memory read outside the tap loop");

   // after the final output of a block the history is empty again
   a_block_clear: assert property (@(posedge clock) disable iff (reset)
      ($past(!reset) && $past(state_ff == firfc_pkg::S_FIN) &&
       (state_ff == firfc_pkg::S_IDLE) && $past(last_ff))
      |-> ((hist_vld_ff == '0) && (wp_ff == '0)))
      else $error("history not cleared at block end");

endmodule

// ===== dv/firfc_checker.sv =====
// firfc_checker: watches the word, output and tap-count channels of the fir core, predicts
// every output word from its own filter state and compares them in order
// depends on firfc_pkg for sizes and command codes
module firfc_checker
   import firfc_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic                          req_cmd,
   input  logic [TAP_INDEX_BITS-1:0]     req_tap_index,
   input  logic signed [COEF_BITS-1:0]   req_tap_value,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   input  logic                          req_last,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic signed [SAMPLE_BITS-1:0] rsp_filtered,
   input  logic                          rsp_clipped,
   input  logic                          rsp_block_end,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [TAP_CFG_BITS-1:0]       csr_tap_count,
   output int                            fail_count,
   output int                            pending
);

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] filtered;
      logic                          clipped;
      logic                          block_end;
   } fir_word_type;

   localparam longint OUT_MAX = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
   localparam longint OUT_MIN = -OUT_MAX - 1;

   // shadow filter state; delay line, head and tap count are set up by the reset branch below
   logic signed [COEF_BITS-1:0]   coef_mem   [MAX_TAPS];
   logic signed [SAMPLE_BITS-1:0] delay_line [MAX_TAPS];
   logic [IDX_BITS-1:0]           head;
   logic [TAP_CFG_BITS-1:0]       taps_cfg;
   fir_word_type                  expected_words [$];
   int                            errors = 0;

   // programmed count clamped into 1..MAX_TAPS
   function automatic int taps_in_use();
      if (taps_cfg == '0) begin
         return 1;
      end
      if (int'(taps_cfg) > MAX_TAPS) begin
         return MAX_TAPS;
      end
      return int'(taps_cfg);
   endfunction

   // shift one sample in and queue the output word it yields
   task automatic push_output(input logic signed [SAMPLE_BITS-1:0] x, input logic end_flag);
      longint       acc;
      fir_word_type w;
      head = head + 1'b1;
      delay_line[head] = x;
      acc = 0;
      for (int k = 0; k < taps_in_use(); k++) begin
         acc += longint'(coef_mem[k]) * longint'(delay_line[IDX_BITS'(head - k)]);
      end
      acc = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      w.clipped = 1'b0;
      if (acc > OUT_MAX) begin
         acc = OUT_MAX;
         w.clipped = 1'b1;
      end else if (acc < OUT_MIN) begin
         acc = OUT_MIN;
         w.clipped = 1'b1;
      end
      w.filtered  = SAMPLE_BITS'(acc);
      w.block_end = end_flag;
      expected_words.push_back(w);
   endtask

   // apply one accepted input word to the shadow state
   task automatic accept_word();
      int n;
      if (req_cmd == CMD_LOAD) begin
         coef_mem[req_tap_index] = req_tap_value;
      end else begin
         n = taps_in_use();
         push_output(req_sample, req_last && n == 1);
         if (req_last) begin
            // tail of the convolution, then a cleared history
            for (int t = 1; t < n; t++) begin
               push_output('0, t == n - 1);
            end
            for (int i = 0; i < MAX_TAPS; i++) begin
               delay_line[i] = '0;
            end
            head = '0;
         end
      end
   endtask

   // compare output words against the oldest prediction
   always @(posedge clock) begin
      fir_word_type want;
      if (reset) begin
         for (int i = 0; i < MAX_TAPS; i++) begin
            delay_line[i] = '0;
         end
         head     = '0;
         taps_cfg = TAP_COUNT_RESET;
         expected_words.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               if (errors < 10) begin
                  $display("[%0t] output word with none predicted: %s %0d %s %0b %s %0b",
                           $realtime, "filtered", rsp_filtered, "clipped", rsp_clipped,
                           "end", rsp_block_end);
               end
               errors++;
            end else begin
               want = expected_words.pop_front();
               if (rsp_filtered !== want.filtered || rsp_clipped !== want.clipped ||
                   rsp_block_end !== want.block_end) begin
                  if (errors < 10) begin
                     $display("[%0t] output mismatch: expected filtered %0d clipped %0b end %0b",
                              $realtime, want.filtered, want.clipped, want.block_end);
                     $display("        got filtered %0d clipped %0b end %0b",
                              rsp_filtered, rsp_clipped, rsp_block_end);
                  end
                  errors++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            taps_cfg = csr_tap_count;
         end
         if (req_valid && req_ready) begin
            accept_word();
         end
      end
      pending    <= expected_words.size();
      fail_count <= errors;
   end

endmodule

// ===== dv/fir_full_convolution_core_tb.sv =====
// fir_full_convolution_core_tb: drives coefficient loads, sample blocks and tap-count writes
// into the fir core with random gaps and output stalls; depends on firfc_pkg, the core and
// firfc_checker, which predicts and compares every output word
module fir_full_convolution_core_tb;
   import firfc_pkg::*;

   localparam int     SETTLE_CYCLES = MAX_TAPS + 16;
   localparam longint LIMIT         = 5_000_000;
   localparam int     ITEM_TARGET   = 480;

   localparam logic signed [COEF_BITS-1:0]   COEF_MAX = {1'b0, {(COEF_BITS-1){1'b1}}};
   localparam logic signed [COEF_BITS-1:0]   COEF_MIN = {1'b1, {(COEF_BITS-1){1'b0}}};
   localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX  = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN  = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_BURSTY} rx_mode_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic                          req_cmd = CMD_LOAD;
   logic [TAP_INDEX_BITS-1:0]     req_tap_index = '0;
   logic signed [COEF_BITS-1:0]   req_tap_value = '0;
   logic signed [SAMPLE_BITS-1:0] req_sample = '0;
   logic                          req_last = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic signed [SAMPLE_BITS-1:0] rsp_filtered;
   logic                          rsp_clipped;
   logic                          rsp_block_end;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [TAP_CFG_BITS-1:0]       csr_tap_count = '0;

   int     fail_count;
   int     pending;
   longint cycle_count = 0;
   int     items_sent = 0;
   int     burst_left = 0;
   int     span = int'(TAP_COUNT_RESET);
   bit [MAX_TAPS-1:0] tap_written = '0;

   rx_mode_type rx_mode = RX_OPEN;
   int          rx_mode_left = 0;
   int          rx_stall_left = 0;

   fir_full_convolution_core u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_cmd       (req_cmd),
      .req_tap_index (req_tap_index),
      .req_tap_value (req_tap_value),
      .req_sample    (req_sample),
      .req_last      (req_last),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_filtered  (rsp_filtered),
      .rsp_clipped   (rsp_clipped),
      .rsp_block_end (rsp_block_end),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_tap_count (csr_tap_count)
   );

   firfc_checker u_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_cmd       (req_cmd),
      .req_tap_index (req_tap_index),
      .req_tap_value (req_tap_value),
      .req_sample    (req_sample),
      .req_last      (req_last),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_filtered  (rsp_filtered),
      .rsp_clipped   (rsp_clipped),
      .rsp_block_end (rsp_block_end),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_tap_count (csr_tap_count),
      .fail_count    (fail_count),
      .pending       (pending)
   );

   // clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT) begin
         $display("** fir_full_convolution_core: FAILED **");
         $finish;
      end
   end

   // output-side stalls, switching between patterns
   always @(posedge clock) begin
      if (rx_mode_left == 0) begin
         rx_mode      <= rx_mode_type'($urandom_range(0, 3));
         rx_mode_left <= $urandom_range(50, 300);
      end else begin
         rx_mode_left <= rx_mode_left - 1;
      end
      case (rx_mode)
         RX_OPEN: begin
            rsp_ready <= 1'b1;
         end
         RX_COIN: begin
            rsp_ready <= 1'($urandom_range(0, 1));
         end
         RX_SPARSE: begin
            rsp_ready <= (cycle_count % 4 == 0);
         end
         default: begin
            if (rx_stall_left > 0) begin
               rsp_ready     <= 1'b0;
               rx_stall_left <= rx_stall_left - 1;
            end else begin
               rsp_ready <= 1'b1;
               if ($urandom_range(0, 15) == 0) begin
                  rx_stall_left <= $urandom_range(5, 20);
               end
            end
         end
      endcase
   end

   function automatic logic signed [COEF_BITS-1:0] rand_coef();
      logic signed [COEF_BITS-1:0] c;
      c = COEF_BITS'($urandom);
      case ($urandom_range(0, 9))
         0: c = COEF_MAX;
         1: c = COEF_MIN;
         2, 3, 4: c = c;
         default: c = c >>> $urandom_range(1, 10);
      endcase
      return c;
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
      logic signed [SAMPLE_BITS-1:0] s;
      s = SAMPLE_BITS'($urandom);
      case ($urandom_range(0, 7))
         0: s = SMP_MAX;
         1: s = SMP_MIN;
         2, 3, 4: s = s;
         default: s = s >>> $urandom_range(3, 12);
      endcase
      return s;
   endfunction

   // present one word, in bursts with random gaps between them
   task automatic send_word(input logic cmd, input logic [TAP_INDEX_BITS-1:0] idx,
                            input logic signed [COEF_BITS-1:0] coef,
                            input logic signed [SAMPLE_BITS-1:0] smp, input logic last);
      int gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = $urandom_range(1, 16);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid     <= 1'b1;
      req_cmd       <= cmd;
      req_tap_index <= idx;
      req_tap_value <= coef;
      req_sample    <= smp;
      req_last      <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      burst_left--;
      items_sent++;
      if (cmd == CMD_LOAD) begin
         tap_written[idx] = 1'b1;
      end
   endtask

   task automatic load_tap(input int idx, input logic signed [COEF_BITS-1:0] coef);
      send_word(CMD_LOAD, TAP_INDEX_BITS'(idx), coef, SAMPLE_BITS'($urandom),
                1'($urandom_range(0, 1)));
   endtask

   // a sample word; any tap in use that was never loaded gets a coefficient first
   task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] smp, input logic last);
      for (int k = 0; k < span; k++) begin
         if (!tap_written[k]) begin
            load_tap(k, rand_coef());
         end
      end
      send_word(CMD_SAMPLE, TAP_INDEX_BITS'($urandom), COEF_BITS'($urandom), smp, last);
   endtask

   // tap-count write once the core has drained
   task automatic write_taps(input logic [TAP_CFG_BITS-1:0] cfg);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid     <= 1'b1;
      csr_tap_count <= cfg;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid  <= 1'b0;
      burst_left = 0;
      span = (cfg == '0) ? 1 : ((int'(cfg) > MAX_TAPS) ? MAX_TAPS : int'(cfg));
   endtask

   // stimulus and verdict
   initial begin
      int  n_blocks;
      int  n_samples;
      bit  open_end;
      logic [TAP_CFG_BITS-1:0] cfg;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: coefficient and sample extremes, saturation both ways
      write_taps(TAP_CFG_BITS'(4));
      load_tap(0, COEF_MAX);
      load_tap(1, COEF_MIN);
      load_tap(2, '0);
      load_tap(3, COEF_BITS'(-1));
      load_tap(MAX_TAPS - 1, rand_coef());
      send_sample(SMP_MAX, 1'b0);
      send_sample(SMP_MIN, 1'b0);
      send_sample(SMP_MAX, 1'b0);
      send_sample('0, 1'b0);
      send_sample(SAMPLE_BITS'(1), 1'b0);
      send_sample(SAMPLE_BITS'(-1), 1'b1);
      // single tap: the last sample alone closes the block
      write_taps(TAP_CFG_BITS'(1));
      send_sample(SMP_MIN, 1'b1);
      send_sample(SAMPLE_BITS'(12345), 1'b1);
      // zero tap count behaves as one tap
      write_taps('0);
      send_sample(SMP_MAX, 1'b0);
      send_sample(SMP_MIN, 1'b1);

      // random phases of sample blocks under varying tap counts
      while (items_sent < ITEM_TARGET) begin
         case ($urandom_range(0, 11))
            0: cfg = TAP_CFG_BITS'(1);
            1: cfg = '0;
            2: cfg = TAP_CFG_BITS'(MAX_TAPS);
            3: cfg = '1;
            4: cfg = TAP_CFG_BITS'($urandom_range(MAX_TAPS + 1, 62));
            5: cfg = TAP_CFG_BITS'($urandom_range(13, MAX_TAPS));
            default: cfg = TAP_CFG_BITS'($urandom_range(2, 12));
         endcase
         write_taps(cfg);
         n_blocks = $urandom_range(1, 4);
         for (int b = 0; b < n_blocks; b++) begin
            open_end = (b == n_blocks - 1) && ($urandom_range(0, 4) == 0);
            repeat ($urandom_range(0, 3)) load_tap($urandom_range(0, MAX_TAPS - 1), rand_coef());
            n_samples = $urandom_range(1, 10);
            for (int i = 0; i < n_samples; i++) begin
               if ($urandom_range(0, 11) == 0) begin
                  load_tap($urandom_range(0, MAX_TAPS - 1), rand_coef());
               end
               send_sample(rand_sample(), (i == n_samples - 1) && !open_end);
            end
         end
      end

      // drain
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("** fir_full_convolution_core: PASSED **");
      end else begin
         $display("** fir_full_convolution_core: FAILED **");
      end
      $finish;
   end

endmodule

// ===== files.f =====
design/firfc_pkg.sv
design/firfc_ram.sv
design/fir_full_convolution_core.sv
dv/firfc_checker.sv
dv/fir_full_convolution_core_tb.sv
